// ===== src/sha1he_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 hash engine package
// Shared item types, sequencer states, round constants and initial hash words.
// ----------------------------------------------------------------------------
package sha1he_pkg;

    // One message word on the input channel
    typedef struct packed {
        logic [31:0] message_word;
        logic [2:0]  valid_bytes;
        logic        last_word;
    } msg_item_t;

    // One digest word on the output channel
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_result;
    } dig_item_t;

    // Working variables of the compression rounds
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } work_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMPRESS,
        ST_ADD,
        ST_OUT
    } state_t;

    localparam int unsigned HASH_WORDS = 5;
    localparam int unsigned BLOCK_WORDS = 16;

    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [6:0] ROUND_B1 = 7'd20;
    localparam logic [6:0] ROUND_B2 = 7'd40;
    localparam logic [6:0] ROUND_B3 = 7'd60;

    localparam logic [3:0] FILL_LAST = 4'd15;
    localparam logic [3:0] FILL_LEN_HI = 4'd14;
    localparam logic [2:0] IDX_LAST = 3'd4;
    localparam logic [2:0] BYTES_FULL = 3'd4;

    localparam logic [31:0] K0 = 32'h5A82_7999;
    localparam logic [31:0] K1 = 32'h6ED9_EBA1;
    localparam logic [31:0] K2 = 32'h8F1B_BCDC;
    localparam logic [31:0] K3 = 32'hCA62_C1D6;

    localparam logic [31:0] PAD_MARKER = 32'h8000_0000;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    localparam logic [31:0] H_INIT [HASH_WORDS] = '{
        32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
    };

endpackage

// ===== src/sha1he_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 round unit
// One compression round: selects the round function and constant by round
// number and produces the next set of working variables.
// ----------------------------------------------------------------------------
module sha1he_round
    import sha1he_pkg::*;
(
    input  work_t       cur,
    input  logic [31:0] w,
    input  logic [6:0]  round,
    output work_t       nxt
);

    logic [31:0] f;
    logic [31:0] k;
    logic [31:0] rot_a;

    // Pick round function and constant
    always_comb
    begin
        if (round < ROUND_B1)
        begin
            f = (cur.b & cur.c) | (~cur.b & cur.d);
            k = K0;
        end
        else if (round < ROUND_B2)
        begin
            f = cur.b ^ cur.c ^ cur.d;
            k = K1;
        end
        else if (round < ROUND_B3)
        begin
            f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
            k = K2;
        end
        else
        begin
            f = cur.b ^ cur.c ^ cur.d;
            k = K3;
        end
    end

    assign rot_a = {cur.a[26:0], cur.a[31:27]};

    // Rotate the working variables
    assign nxt.a = rot_a + f + cur.e + w + k;
    assign nxt.b = cur.a;
    assign nxt.c = {cur.b[1:0], cur.b[31:2]};
    assign nxt.d = cur.c;
    assign nxt.e = cur.d;

endmodule

// ===== src/sha1_hash_engine_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 hash engine
// Streams big-endian message words, pads the final block and returns the
// five words of the 160-bit digest.
// ----------------------------------------------------------------------------
// A word that does not complete a 16-word block is taken and leaves the engine
// ready for the next word. A word that completes a block keeps the engine busy
// while it is stored, passes through every round of the single round unit
// (one round per cycle) and has its result folded into the chaining words;
// the input stays stalled until that is done. The last word of a message is
// followed by the padding pushes, one word per cycle except while a
// compression runs (one or two of them), then five digest transfers, which
// the output stall can hold.
// ----------------------------------------------------------------------------
module sha1_hash_engine_unit
    import sha1he_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      msg_valid,
    output logic      msg_stall,
    input  msg_item_t msg,
    output logic      dig_valid,
    input  logic      dig_stall,
    output dig_item_t dig
);

    state_t      state_reg, state_next;
    logic [3:0]  fill_reg, fill_next;
    logic [6:0]  round_reg, round_next;
    logic [2:0]  idx_reg, idx_next;
    logic [63:0] bitlen_reg, bitlen_next;
    logic        finish_reg, finish_next;
    logic        marker_reg, marker_next;
    logic        hi_done_reg, hi_done_next;
    logic        lo_done_reg, lo_done_next;
    logic [31:0] chain_reg [HASH_WORDS];
    logic [31:0] chain_next [HASH_WORDS];
    work_t       work_reg, work_next;
    logic [31:0] sched_reg [BLOCK_WORDS];
    logic [31:0] sched_next [BLOCK_WORDS];

    logic        push_en;
    logic [31:0] push_data;
    logic        accept;
    logic [2:0]  nbytes;
    logic [31:0] last_data;
    logic [31:0] w_mix;
    logic [31:0] w_new;
    work_t       round_out;

    assign accept = msg_valid && !msg_stall;
    assign msg_stall = (state_reg != ST_IDLE);

    // Byte count of the incoming word: short only on the last word
    assign nbytes = (msg.last_word && (msg.valid_bytes < BYTES_FULL)) ?
                    msg.valid_bytes : BYTES_FULL;

    // Truncate the last word and, when it is short, place the pad byte after its data
    always_comb
    begin
        case (nbytes)
            3'd0:    last_data = PAD_MARKER;
            3'd1:    last_data = {msg.message_word[31:24], PAD_BYTE, 16'h0000};
            3'd2:    last_data = {msg.message_word[31:16], PAD_BYTE, 8'h00};
            3'd3:    last_data = {msg.message_word[31:8], PAD_BYTE};
            default: last_data = msg.message_word;
        endcase
    end

    // Message schedule expansion taps
    assign w_mix = sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0];
    assign w_new = {w_mix[30:0], w_mix[31]};

    sha1he_round u_round (
        .cur   (work_reg),
        .w     (sched_reg[0]),
        .round (round_reg),
        .nxt   (round_out)
    );

    // Sequencer: next state, pushes and outputs
    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        round_next   = round_reg;
        idx_next     = idx_reg;
        bitlen_next  = bitlen_reg;
        finish_next  = finish_reg;
        marker_next  = marker_reg;
        hi_done_next = hi_done_reg;
        lo_done_next = lo_done_reg;
        work_next    = work_reg;
        for (int i = 0; i < HASH_WORDS; i++)
        begin
            chain_next[i] = chain_reg[i];
        end
        push_en   = 1'b0;
        push_data = '0;
        dig_valid = 1'b0;
        dig.digest_word = chain_reg[idx_reg];
        dig.word_index  = idx_reg;
        dig.last_result = (idx_reg == IDX_LAST);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    push_en     = 1'b1;
                    push_data   = msg.last_word ? last_data : msg.message_word;
                    bitlen_next = bitlen_reg + {58'd0, nbytes, 3'b000};
                    finish_next = msg.last_word;
                    marker_next = msg.last_word && (nbytes == BYTES_FULL);
                    state_next  = msg.last_word ? ST_PAD : ST_IDLE;
                end
            end
            ST_PAD:
            begin
                push_en = 1'b1;
                if (marker_reg)
                begin
                    push_data   = PAD_MARKER;
                    marker_next = 1'b0;
                end
                else if (fill_reg == FILL_LEN_HI)
                begin
                    push_data    = bitlen_reg[63:32];
                    hi_done_next = 1'b1;
                end
                else if ((fill_reg == FILL_LAST) && hi_done_reg)
                begin
                    push_data    = bitlen_reg[31:0];
                    lo_done_next = 1'b1;
                end
                else
                begin
                    push_data = '0;
                end
            end
            ST_COMPRESS:
            begin
                work_next  = round_out;
                round_next = round_reg + 7'd1;
                if (round_reg == LAST_ROUND)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                chain_next[0] = chain_reg[0] + work_reg.a;
                chain_next[1] = chain_reg[1] + work_reg.b;
                chain_next[2] = chain_reg[2] + work_reg.c;
                chain_next[3] = chain_reg[3] + work_reg.d;
                chain_next[4] = chain_reg[4] + work_reg.e;
                idx_next = '0;
                if (lo_done_reg)
                begin
                    state_next = ST_OUT;
                end
                else if (finish_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                dig_valid = 1'b1;
                if (!dig_stall)
                begin
                    if (idx_reg == IDX_LAST)
                    begin
                        for (int i = 0; i < HASH_WORDS; i++)
                        begin
                            chain_next[i] = H_INIT[i];
                        end
                        bitlen_next  = '0;
                        finish_next  = 1'b0;
                        marker_next  = 1'b0;
                        hi_done_next = 1'b0;
                        lo_done_next = 1'b0;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Advance fill count; a full block starts the rounds
        if (push_en)
        begin
            fill_next = fill_reg + 4'd1;
            if (fill_reg == FILL_LAST)
            begin
                state_next = ST_COMPRESS;
                round_next = '0;
                work_next  = '{a: chain_reg[0], b: chain_reg[1], c: chain_reg[2],
                               d: chain_reg[3], e: chain_reg[4]};
            end
        end
    end

    // Shift the block buffer: pushes fill it, rounds expand it
    always_comb
    begin
        for (int i = 0; i < BLOCK_WORDS - 1; i++)
        begin
            sched_next[i] = sched_reg[i + 1];
        end
        sched_next[BLOCK_WORDS - 1] = push_en ? push_data : w_new;
        if (!push_en && (state_reg != ST_COMPRESS))
        begin
            for (int i = 0; i < BLOCK_WORDS; i++)
            begin
                sched_next[i] = sched_reg[i];
            end
        end
    end

    // Control and chaining state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            round_reg   <= '0;
            idx_reg     <= '0;
            bitlen_reg  <= '0;
            finish_reg  <= 1'b0;
            marker_reg  <= 1'b0;
            hi_done_reg <= 1'b0;
            lo_done_reg <= 1'b0;
            for (int i = 0; i < HASH_WORDS; i++)
            begin
                chain_reg[i] <= H_INIT[i];
            end
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            round_reg   <= round_next;
            idx_reg     <= idx_next;
            bitlen_reg  <= bitlen_next;
            finish_reg  <= finish_next;
            marker_reg  <= marker_next;
            hi_done_reg <= hi_done_next;
            lo_done_reg <= lo_done_next;
            for (int i = 0; i < HASH_WORDS; i++)
            begin
                chain_reg[i] <= chain_next[i];
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        for (int i = 0; i < BLOCK_WORDS; i++)
        begin
            sched_reg[i] <= sched_next[i];
        end
    end

    // A digest is only shown once the final block has been absorbed
    a_out_block_done: assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid |-> (fill_reg == 4'd0) && lo_done_reg)
        else $error("digest shown with block data pending");

    // Round counter never passes the last round while compressing
    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMPRESS) |-> (round_reg <= LAST_ROUND))
        else $error("round counter out of range");

    // Final digest transfer restores the initial chaining value
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (dig_valid && !dig_stall && dig.last_result) |=>
        (chain_reg[0] == H_INIT[0]) && (bitlen_reg == 64'd0) && !msg_stall)
        else $error("engine not restarted after digest");

    // The high length word goes in only during padding of the final block
    a_len_in_pad: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(hi_done_reg) |-> $past(state_reg) == ST_PAD && finish_reg)
        else $error("length word pushed outside padding");

endmodule
